// ===== hdl/mep_pkg.sv =====
// Shared constants and helpers for the escape-time pixel block.
// Fixed-point widths, register indexes, reset values and coordinate saturation.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package mep_pkg;

  localparam int FRAC_BITS  = 24;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int ORIGIN_W   = 32;
  localparam int STEP_W     = 25;
  localparam int ITER_W     = 12;
  localparam int COUNT_W    = 13;
  localparam int IDX_W      = 10;
  localparam int COLOR_W    = 8;

  // multiplier operand: magnitudes up to 2.0 in Q.24, indexes up to 1023
  localparam int MUL_W  = FRAC_BITS + 2;
  localparam int PROD_W = 2 * MUL_W;
  // iterate register: |z| <= 2 before a step, plus c up to 128
  localparam int Z_W    = 34;
  localparam int SUM_W  = 38;

  localparam int DEF_IMAGE_WIDTH  = 1024;
  localparam int DEF_IMAGE_HEIGHT = 1024;

  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_RE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_IM = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_RE   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_IM   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_ITER  = 3'd4;

  localparam logic [ORIGIN_W-1:0] RST_ORIGIN_RE = 32'hFE00_0000;  // -2.0
  localparam logic [ORIGIN_W-1:0] RST_ORIGIN_IM = 32'hFE80_0000;  // -1.5
  localparam logic [STEP_W-1:0]   RST_STEP      = 25'd98304;      // 3/512
  localparam logic [ITER_W-1:0]   RST_MAX_ITER  = 12'd100;

  // |z|^2 > 4 in Q.48
  localparam logic [PROD_W-1:0] ESCAPE_LIMIT = PROD_W'(1) << (2 * FRAC_BITS + 2);
  // a component above 2.0 escapes without squaring it
  localparam logic [Z_W-1:0]    MAG_LIMIT    = Z_W'(1) << (FRAC_BITS + 1);

  localparam logic [COLOR_W-1:0] RAMP_BASE_RG   = 8'd50;
  localparam logic [COLOR_W-1:0] RAMP_BASE_B    = 8'd100;
  localparam logic [COLOR_W-1:0] MAGENTA_OFFSET = 8'd150;

  // origin + index*step, clipped at the Q8.24 maximum (the sum never goes below origin)
  function automatic logic [ORIGIN_W-1:0] sat_coord(input logic [ORIGIN_W-1:0] origin,
                                                    input logic [PROD_W-1:0] prod);
    logic signed [SUM_W-1:0] s;
    s = signed'({{(SUM_W-ORIGIN_W){origin[ORIGIN_W-1]}}, origin})
      + signed'({2'b00, prod[SUM_W-3:0]});
    if (s > SUM_W'(signed'(33'h0_7FFF_FFFF))) begin
      return 32'h7FFF_FFFF;
    end
    return s[ORIGIN_W-1:0];
  endfunction

  function automatic logic [Z_W-1:0] mag_z(input logic [Z_W-1:0] v);
    return v[Z_W-1] ? (~v + Z_W'(1)) : v;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/mandelbrot_escape_pixel.sv =====
// Escape-time pixel engine: maps (column, row) to an iteration count and a color.
// Depends on mep_pkg.
//
// One request at a time. A pixel runs until the iterate escapes (or until a
// component leaves the radius by itself), and for max_iter steps for a bounded
// point. Every product, the pixel coordinates and the three products of each
// step, goes through a single registered 26x26 multiplier, so a step passes
// through the states S_SQX, S_SQY, S_XY and S_UPD in turn. in_stall is
// high from the accepted request until its result is handed to the output
// register; a finished result may wait there while the next request is taken.
`timescale 1ns / 1ps
`default_nettype none

module mandelbrot_escape_pixel #(
  parameter int IMAGE_WIDTH  = mep_pkg::DEF_IMAGE_WIDTH,
  parameter int IMAGE_HEIGHT = mep_pkg::DEF_IMAGE_HEIGHT
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               cfg_write,
  input  wire logic [mep_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [mep_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  wire logic                               in_valid,
  output logic                                    in_stall,
  input  wire logic [mep_pkg::IDX_W-1:0]          column,
  input  wire logic [mep_pkg::IDX_W-1:0]          row,
  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output logic [mep_pkg::COUNT_W-1:0]             escape_count,
  output logic [mep_pkg::COLOR_W-1:0]             red,
  output logic [mep_pkg::COLOR_W-1:0]             green,
  output logic [mep_pkg::COLOR_W-1:0]             blue
);
  import mep_pkg::*;

  localparam int ColW = (IMAGE_WIDTH > 2) ? $clog2(IMAGE_WIDTH) : 1;
  localparam int RowW = (IMAGE_HEIGHT > 2) ? $clog2(IMAGE_HEIGHT) : 1;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_CRE  = 4'd1;  // column * step_re
  localparam logic [3:0] S_CIM  = 4'd2;  // take c_re, row * step_im
  localparam logic [3:0] S_CFIN = 4'd3;  // take c_im, clear z
  localparam logic [3:0] S_SQX  = 4'd4;  // x*x
  localparam logic [3:0] S_SQY  = 4'd5;  // y*y
  localparam logic [3:0] S_XY   = 4'd6;  // x*y, escape test
  localparam logic [3:0] S_UPD  = 4'd7;  // z = z*z + c
  localparam logic [3:0] S_DONE = 4'd8;

  logic [3:0]          state;

  logic [ORIGIN_W-1:0] origin_re;
  logic [ORIGIN_W-1:0] origin_im;
  logic [STEP_W-1:0]   step_re;
  logic [STEP_W-1:0]   step_im;
  logic [ITER_W-1:0]   max_iter;

  logic [ColW-1:0]     col_idx;
  logic [RowW-1:0]     row_idx;
  logic [ITER_W-1:0]   lim;
  logic [ITER_W-1:0]   k;
  logic [COUNT_W-1:0]  count;

  logic [ORIGIN_W-1:0] cx;
  logic [ORIGIN_W-1:0] cy;
  logic [Z_W-1:0]      x;
  logic [Z_W-1:0]      y;
  logic [PROD_W-1:0]   sqx;
  logic [PROD_W-1:0]   sqy;

  logic [MUL_W-1:0]    mul_a;
  logic [MUL_W-1:0]    mul_b;
  logic [PROD_W-1:0]   prod;

  logic [Z_W-1:0]      ax;
  logic [Z_W-1:0]      ay;
  logic                big;
  logic [PROD_W-1:0]   mag_sq;
  logic [Z_W-1:0]      xy2;
  logic [Z_W-1:0]      x_next;
  logic [Z_W-1:0]      y_next;

  logic [COUNT_W-1:0]  half;
  logic [COLOR_W-1:0]  red_next;
  logic [COLOR_W-1:0]  green_next;
  logic [COLOR_W-1:0]  blue_next;
  logic                out_load;

  assign in_stall = (state != S_IDLE);
  assign out_load = (state == S_DONE) && (!out_valid || !out_stall);

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      origin_re <= RST_ORIGIN_RE;
      origin_im <= RST_ORIGIN_IM;
      step_re   <= RST_STEP;
      step_im   <= RST_STEP;
      max_iter  <= RST_MAX_ITER;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_ORIGIN_RE: origin_re <= cfg_data;
        REG_ORIGIN_IM: origin_im <= cfg_data;
        REG_STEP_RE:   step_re   <= cfg_data[STEP_W-1:0];
        REG_STEP_IM:   step_im   <= cfg_data[STEP_W-1:0];
        REG_MAX_ITER:  max_iter  <= cfg_data[ITER_W-1:0];
        default: ;
      endcase
    end
  end

  // shared multiplier operand select
  assign ax = mag_z(x);
  assign ay = mag_z(y);
  assign big = (ax > MAG_LIMIT) || (ay > MAG_LIMIT);

  always_comb begin
    case (state)
      S_CRE: begin
        mul_a = MUL_W'(col_idx);
        mul_b = MUL_W'(step_re);
      end
      S_CIM: begin
        mul_a = MUL_W'(row_idx);
        mul_b = MUL_W'(step_im);
      end
      S_SQX: begin
        mul_a = ax[MUL_W-1:0];
        mul_b = ax[MUL_W-1:0];
      end
      S_SQY: begin
        mul_a = ay[MUL_W-1:0];
        mul_b = ay[MUL_W-1:0];
      end
      S_XY: begin
        mul_a = ax[MUL_W-1:0];
        mul_b = ay[MUL_W-1:0];
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= {{MUL_W{1'b0}}, mul_a} * {{MUL_W{1'b0}}, mul_b};
  end

  // escape test in S_XY: x^2 is in sqx, y^2 has just arrived in prod
  assign mag_sq = sqx + prod;

  // step update in S_UPD: prod holds |x|*|y|
  always_comb begin
    xy2 = Z_W'(prod >> (FRAC_BITS - 1));
    if (x[Z_W-1] != y[Z_W-1]) begin
      xy2 = ~xy2 + Z_W'(1);
    end
    x_next = Z_W'(sqx >> FRAC_BITS) - Z_W'(sqy >> FRAC_BITS)
           + {{(Z_W-ORIGIN_W){cx[ORIGIN_W-1]}}, cx};
    y_next = xy2 + {{(Z_W-ORIGIN_W){cy[ORIGIN_W-1]}}, cy};
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= S_CRE;
          end
        end
        S_CRE:  state <= S_CIM;
        S_CIM:  state <= S_CFIN;
        S_CFIN: state <= S_SQX;
        S_SQX: begin
          if (big) begin
            state <= S_DONE;
          end else begin
            state <= S_SQY;
          end
        end
        S_SQY: state <= S_XY;
        S_XY: begin
          if (((k != '0) && (mag_sq > ESCAPE_LIMIT)) || (k == lim)) begin
            state <= S_DONE;
          end else begin
            state <= S_UPD;
          end
        end
        S_UPD: state <= S_SQX;
        S_DONE: begin
          if (!out_valid || !out_stall) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (32'(column) > 32'(IMAGE_WIDTH - 1)) begin
          col_idx <= ColW'(IMAGE_WIDTH - 1);
        end else begin
          col_idx <= ColW'(column);
        end
        if (32'(row) > 32'(IMAGE_HEIGHT - 1)) begin
          row_idx <= RowW'(IMAGE_HEIGHT - 1);
        end else begin
          row_idx <= RowW'(row);
        end
        lim <= max_iter;
      end
      S_CIM: cx <= sat_coord(origin_re, prod);
      S_CFIN: begin
        cy <= sat_coord(origin_im, prod);
        x  <= '0;
        y  <= '0;
        k  <= '0;
      end
      S_SQX: begin
        if (big) begin
          count <= COUNT_W'(k);
        end
      end
      S_SQY: sqx <= prod;
      S_XY: begin
        sqy <= prod;
        if ((k != '0) && (mag_sq > ESCAPE_LIMIT)) begin
          count <= COUNT_W'(k);
        end else begin
          count <= COUNT_W'(lim) + COUNT_W'(1);
        end
      end
      S_UPD: begin
        x <= x_next;
        y <= y_next;
        k <= k + ITER_W'(1);
      end
      default: ;
    endcase
  end

  // color ramp, bytes wrap
  always_comb begin
    half = COUNT_W'(lim >> 1);
    red_next   = '0;
    green_next = '0;
    blue_next  = '0;
    if (count <= half) begin
      red_next   = {count[COLOR_W-3:0], 2'b00} + RAMP_BASE_RG;
      green_next = red_next;
      blue_next  = count[COLOR_W-1:0] + {count[COLOR_W-2:0], 1'b0} + RAMP_BASE_B;
    end else if (count < COUNT_W'(lim)) begin
      red_next  = count[COLOR_W-1:0] + MAGENTA_OFFSET;
      blue_next = red_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      escape_count <= count;
      red          <= red_next;
      green        <= green_next;
      blue         <= blue_next;
    end
  end

`ifndef NO_ASSERTIONS
  a_step_within_limit: assert property (@(posedge clk) disable iff (rst)
    (state == S_UPD) |-> (k < lim))
    else $error("step issued past the iteration limit");

  a_operands_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_SQY) |-> !big)
    else $error("multiplier fed a component above the escape radius");

  a_result_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == S_DONE))
    else $error("result appeared without a finished pixel");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ((escape_count != '0)
                          && (escape_count <= (COUNT_W'(lim) + COUNT_W'(1)))))
    else $error("escape count out of range");

  a_busy_until_done: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> (state == S_CRE))
    else $error("accepted request did not start the sequencer");
`endif

endmodule

`default_nettype wire
